### design/sync_crc_frame_parser_assert.svh
// Assertion macros for the frame parser.
`ifndef SYNC_CRC_FRAME_PARSER_ASSERT_SVH
`define SYNC_CRC_FRAME_PARSER_ASSERT_SVH
// Overlapping (same-cycle) implication checked on every clock edge outside reset.
`define SCFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define SCFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### design/scfp_pkg.sv
// ----------------------------------------------------------------------------
// scfp_pkg
// Types and constants shared by the sync-word frame parser.
// ----------------------------------------------------------------------------
package scfp_pkg;
  localparam int FRAME_BYTES_DEF = 20;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam logic [7:0] SYNC_A = 8'hA5;
  localparam logic [7:0] SYNC_B = 8'h5A;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CONF_MAX = 16'd1000;

  localparam logic [2:0] REG_VERSION = 3'd0;
  localparam logic [2:0] REG_MSG_TYPE = 3'd1;
  localparam logic [2:0] REG_PAYLOAD = 3'd2;
  localparam logic [2:0] REG_HI_REASON = 3'd3;
  localparam logic [2:0] REG_OK_REASON = 3'd4;
  localparam logic [2:0] REG_POS_MARK = 3'd5;
  localparam logic [2:0] REG_AGE_MARK = 3'd6;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_OK = 3'd1;
  localparam logic [2:0] EV_CRC = 3'd2;
  localparam logic [2:0] EV_FORMAT = 3'd3;
  localparam logic [2:0] EV_SEMANTIC = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [31:0] rx_time_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic resynced;
    logic [31:0] sender_uptime_ms;
    logic [31:0] rx_time_out;
    logic signed [15:0] position;
    logic [9:0] confidence;
    logic [15:0] frame_age_ms;
    logic [7:0] sequence_res;
    logic [7:0] reason;
    logic observation_valid;
  } out_item_t;
endpackage

### design/scfp_stream_if.sv
// ----------------------------------------------------------------------------
// scfp_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface scfp_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/sync_crc_frame_parser.sv
// ----------------------------------------------------------------------------
// sync_crc_frame_parser
// Hunts for the A5 5A sync pair, collects a frame, checks CRC-16/MODBUS,
// format and semantic rules, and resynchronizes after a rejected frame.
// ----------------------------------------------------------------------------
//   channel   direction   payload
//   in_ch     sink        rx_byte, rx_time_ms
//   out_ch    source      event_res .. observation_valid
//   cfg       write port  cfg_we, cfg_idx, cfg_data
// Every input item yields one result item. A completing byte starts a sweep
// over the frame memory with a bit-serial CRC update over each body byte;
// a rejected frame adds a resync search and copy. Reset is synchronous and
// clears the fill count and the sequencer. A stalled output holds the block.
// ----------------------------------------------------------------------------
module sync_crc_frame_parser #(
  parameter int FRAME_BYTES = scfp_pkg::FRAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  scfp_stream_if.sink                   in_ch,
  scfp_stream_if.source                 out_ch,
  input  logic                          cfg_we,
  input  logic [scfp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [scfp_pkg::CFG_W-1:0]    cfg_data
);
  import scfp_pkg::*;
  `include "sync_crc_frame_parser_assert.svh"

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam logic [CW-1:0] FULL = CW'(FRAME_BYTES);
  localparam logic [AW-1:0] LAST = AW'(FRAME_BYTES - 1);
  localparam logic [AW-1:0] CRC_END = AW'(FRAME_BYTES - 3);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD = 4'd1;
  localparam logic [3:0] S_CAP = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_SRCH_RD = 4'd5;
  localparam logic [3:0] S_SRCH = 4'd6;
  localparam logic [3:0] S_MOVE_RD = 4'd7;
  localparam logic [3:0] S_MOVE = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;

  // Configuration registers.
  logic [7:0] protocol_version, message_type, payload_length;
  logic [7:0] highest_reason, ok_reason;
  logic [15:0] invalid_position_mark, unknown_age_mark;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version <= 8'd1;
      message_type <= 8'd1;
      payload_length <= 8'd12;
      highest_reason <= 8'd3;
      ok_reason <= 8'd0;
      invalid_position_mark <= 16'h8000;
      unknown_age_mark <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_VERSION: protocol_version <= cfg_data[7:0];
        REG_MSG_TYPE: message_type <= cfg_data[7:0];
        REG_PAYLOAD: payload_length <= cfg_data[7:0];
        REG_HI_REASON: highest_reason <= cfg_data[7:0];
        REG_OK_REASON: ok_reason <= cfg_data[7:0];
        REG_POS_MARK: invalid_position_mark <= cfg_data;
        REG_AGE_MARK: unknown_age_mark <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  logic [3:0] state;
  logic [CW-1:0] fill_count;
  logic [AW-1:0] ptr, src, dst;
  logic [2:0] bit_cnt;
  logic [15:0] crc;
  logic [7:0] prev_byte;
  logic [31:0] rx_time, tx_uptime;
  logic [7:0] b2, b3, b4, b5, b10, b11;
  logic [15:0] pos_w, conf_w, age_w, crc_rx;
  logic found;
  out_item_t out_q;

  // Frame memory.
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata, rdata;

  scfp_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data = out_q;

  // Check logic on the captured fields.
  logic [2:0] verdict;
  always_comb begin
    logic sem_bad;
    sem_bad = (b10 > 8'd1) || (b11 > highest_reason) || (conf_w > CONF_MAX) ||
              ((b10 != 8'd0) && ((b11 != ok_reason) || (pos_w == invalid_position_mark) ||
                                 (age_w == unknown_age_mark))) ||
              ((b10 == 8'd0) && ((b11 == ok_reason) || (pos_w != invalid_position_mark)));
    if (crc_rx != crc) verdict = EV_CRC;
    else if ((b2 != protocol_version) || (b3 != message_type) || (b5 != payload_length))
      verdict = EV_FORMAT;
    else if (sem_bad) verdict = EV_SEMANTIC;
    else verdict = EV_OK;
  end

  // Memory port control.
  always_comb begin
    we = 1'b0;
    waddr = fill_count[AW-1:0];
    wdata = in_ch.data.rx_byte;
    raddr = ptr;
    if (state == S_IDLE && accept) begin
      we = (fill_count != '0) || (in_ch.data.rx_byte == SYNC_A);
      if (fill_count == CW'(1) && in_ch.data.rx_byte != SYNC_B) waddr = '0;
    end else if (state == S_MOVE) begin
      we = 1'b1;
      waddr = dst;
      wdata = rdata;
    end else if (state == S_MOVE_RD) begin
      raddr = src;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill_count <= '0;
    end else begin
      case (state)
        S_IDLE: if (accept) begin
          out_q <= '0;
          rx_time <= in_ch.data.rx_time_ms;
          if (fill_count == '0) begin
            if (in_ch.data.rx_byte == SYNC_A) fill_count <= CW'(1);
            state <= S_OUT;
          end else if (fill_count == CW'(1)) begin
            if (in_ch.data.rx_byte == SYNC_B) fill_count <= CW'(2);
            else if (in_ch.data.rx_byte != SYNC_A) fill_count <= '0;
            state <= S_OUT;
          end else if (fill_count == FULL - CW'(1)) begin
            crc_rx[15:8] <= in_ch.data.rx_byte;
            crc <= CRC_INIT;
            ptr <= '0;
            state <= S_RD;
          end else begin
            fill_count <= fill_count + CW'(1);
            state <= S_OUT;
          end
        end
        // Sweep the frame, one byte read at a time through the registered RAM port.
        S_RD: state <= S_CAP;
        S_CAP: begin
          bit_cnt <= '0;
          case (ptr)
            AW'(2): b2 <= rdata;
            AW'(3): b3 <= rdata;
            AW'(4): b4 <= rdata;
            AW'(5): b5 <= rdata;
            AW'(6): tx_uptime[7:0] <= rdata;
            AW'(7): tx_uptime[15:8] <= rdata;
            AW'(8): tx_uptime[23:16] <= rdata;
            AW'(9): tx_uptime[31:24] <= rdata;
            AW'(10): b10 <= rdata;
            AW'(11): b11 <= rdata;
            AW'(12): pos_w[7:0] <= rdata;
            AW'(13): pos_w[15:8] <= rdata;
            AW'(14): conf_w[7:0] <= rdata;
            AW'(15): conf_w[15:8] <= rdata;
            AW'(16): age_w[7:0] <= rdata;
            AW'(17): age_w[15:8] <= rdata;
            AW'(18): crc_rx[7:0] <= rdata;
            default: ;
          endcase
          if (ptr >= AW'(2) && ptr <= CRC_END) begin
            crc <= crc ^ {8'h00, rdata};
            state <= S_SHIFT;
          end else if (ptr == LAST - AW'(1)) begin
            state <= S_DECIDE;
          end else begin
            ptr <= ptr + AW'(1);
            state <= S_RD;
          end
        end
        // Shared CRC shifter, one bit per cycle.
        S_SHIFT: begin
          crc <= crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            ptr <= ptr + AW'(1);
            state <= S_RD;
          end
        end
        S_DECIDE: begin
          out_q.event_res <= verdict;
          if (verdict == EV_OK) begin
            out_q.sender_uptime_ms <= tx_uptime;
            out_q.rx_time_out <= rx_time;
            out_q.position <= pos_w;
            out_q.confidence <= conf_w[9:0];
            out_q.frame_age_ms <= age_w;
            out_q.sequence_res <= b4;
            out_q.reason <= b11;
            out_q.observation_valid <= b10[0];
            fill_count <= '0;
            state <= S_OUT;
          end else begin
            out_q.resynced <= 1'b1;
            ptr <= AW'(1);
            found <= 1'b0;
            state <= S_SRCH_RD;
          end
        end
        // Search for a later sync pair; the final byte is also held in crc_rx.
        S_SRCH_RD: state <= S_SRCH;
        S_SRCH: begin
          prev_byte <= rdata;
          if (ptr >= AW'(2) && prev_byte == SYNC_A && rdata == SYNC_B) begin
            src <= ptr - AW'(1);
            dst <= '0;
            fill_count <= FULL - CW'(ptr - AW'(1));
            found <= 1'b1;
            state <= S_MOVE_RD;
          end else if (ptr == LAST - AW'(1)) begin
            if (rdata == SYNC_A && crc_rx[15:8] == SYNC_B) begin
              src <= ptr;
              dst <= '0;
              fill_count <= CW'(2);
              found <= 1'b1;
              state <= S_MOVE_RD;
            end else if (crc_rx[15:8] == SYNC_A) begin
              fill_count <= CW'(1);
              src <= LAST;
              dst <= '0;
              state <= S_MOVE_RD;
            end else begin
              fill_count <= '0;
              state <= S_OUT;
            end
          end else begin
            ptr <= ptr + AW'(1);
            state <= S_SRCH_RD;
          end
        end
        // Copy kept bytes down, one read and one write per byte.
        S_MOVE_RD: state <= S_MOVE;
        S_MOVE: begin
          if (src == LAST - AW'(1)) begin
            src <= LAST;
            dst <= dst + AW'(1);
            state <= S_MOVE_RD;
          end else if (src == LAST || !found) begin
            state <= S_OUT;
          end else begin
            src <= src + AW'(1);
            dst <= dst + AW'(1);
            state <= S_MOVE_RD;
          end
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `SCFP_ASSERT_IMP(a_fill_range, 1'b1, fill_count < FULL, "fill count out of range")
  `SCFP_ASSERT_IMP(a_busy_ready, state != S_IDLE, !in_ch.ready, "ready while busy")
  `SCFP_ASSERT_NEXT(a_take_out, out_ch.valid && out_ch.ready, state == S_IDLE,
                    "result not retired")
endmodule

### design/scfp_ram.sv
// ----------------------------------------------------------------------------
// scfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
